// ===== sv/ihp_pkg.sv =====
// Shared types and constants for the IPv4 header parser.
package ihp_pkg;

    // Header layout and limits
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [3:0]  MIN_IHL          = 4'd5;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [15:0] SUM_ALL_ONES     = 16'hFFFF;

    // Byte offsets of captured header fields
    localparam logic [15:0] IDX_VER_IHL  = 16'd0;
    localparam logic [15:0] IDX_LEN_HI   = 16'd2;
    localparam logic [15:0] IDX_LEN_LO   = 16'd3;
    localparam logic [15:0] IDX_TTL      = 16'd8;
    localparam logic [15:0] IDX_PROTO    = 16'd9;
    localparam logic [15:0] IDX_SRC_LO   = 16'd12;
    localparam logic [15:0] IDX_SRC_HI   = 16'd15;
    localparam logic [15:0] IDX_DST_LO   = 16'd16;
    localparam logic [15:0] IDX_DST_HI   = 16'd19;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_IHL     = 3'd3,
        ST_LEN_OVER    = 3'd4,
        ST_LEN_UNDER   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       direction;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  header_words;
        logic [7:0]  hop_limit;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] datagram_length;
        logic        checksum_good;
        logic        direction_out;
        logic [15:0] payload_length;
    } t_out_item;

    // Control from the field tracker to the checksum accumulator
    typedef struct packed {
        logic en;       // a byte advances this cycle
        logic clear;    // final byte: return to idle after this byte
        logic in_span;  // byte lies inside the IHL*4 header
        logic odd;      // byte completes a 16-bit word
    } t_sum_ctl;

endpackage

// ===== sv/ihp_checksum.sv =====
// Ones'-complement header checksum accumulator, one byte per transaction.
module ihp_checksum
    import ihp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sum_ctl   i_ctl,
    input  logic [7:0] i_data_byte,
    output logic       o_sum_good
);

    logic [15:0] r_sum;
    logic [7:0]  r_high;
    logic [15:0] n_sum;
    logic [7:0]  n_high;
    logic [16:0] wide_sum;
    logic [15:0] folded;
    logic [15:0] sum_after;

    // Add the completed word and fold the carry back in
    always_comb begin
        wide_sum = {1'b0, r_sum} + {1'b0, r_high, i_data_byte};
        folded   = wide_sum[15:0] + {15'd0, wide_sum[16]};
    end

    // Sum as it stands once this byte is taken
    assign sum_after  = (i_ctl.in_span && i_ctl.odd) ? folded : r_sum;
    assign o_sum_good = (sum_after == SUM_ALL_ONES);

    // Next state: hold even bytes, accumulate on odd bytes, clear at packet end
    always_comb begin
        n_sum  = r_sum;
        n_high = r_high;
        if (i_ctl.en) begin
            if (i_ctl.clear) begin
                n_sum  = 16'd0;
                n_high = 8'd0;
            end else if (i_ctl.in_span) begin
                if (i_ctl.odd) begin
                    n_sum = folded;
                end else begin
                    n_high = i_data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 16'd0;
            r_high <= 8'd0;
        end else begin
            r_sum  <= n_sum;
            r_high <= n_high;
        end
    end

endmodule

// ===== sv/ihp_fields.sv =====
// Byte counter, header field capture and final status/result build.
module ihp_fields
    import ihp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_item  i_item,
    input  logic      i_sum_good,
    output t_sum_ctl  o_sum_ctl,
    output t_out_item o_result
);

    logic [15:0] r_count;
    logic [7:0]  r_first;
    logic [15:0] r_length;
    logic [7:0]  r_ttl;
    logic [7:0]  r_proto;
    logic [31:0] r_src;
    logic [31:0] r_dst;

    logic [15:0] n_count;
    logic [7:0]  n_first;
    logic [15:0] n_length;
    logic [7:0]  n_ttl;
    logic [7:0]  n_proto;
    logic [31:0] n_src;
    logic [31:0] n_dst;

    logic [7:0]  b;
    logic [3:0]  ihl;
    logic [3:0]  version;
    logic [15:0] hdr_bytes;
    t_status     status;

    assign b = i_item.data_byte;

    // Capture header fields at their byte offsets
    always_comb begin
        n_first  = (r_count == IDX_VER_IHL) ? b : r_first;
        n_length = r_length;
        if (r_count == IDX_LEN_HI) begin
            n_length = {b, r_length[7:0]};
        end
        if (r_count == IDX_LEN_LO) begin
            n_length = {r_length[15:8], b};
        end
        n_ttl   = (r_count == IDX_TTL)   ? b : r_ttl;
        n_proto = (r_count == IDX_PROTO) ? b : r_proto;
        n_src   = (r_count >= IDX_SRC_LO && r_count <= IDX_SRC_HI) ?
                  {r_src[23:0], b} : r_src;
        n_dst   = (r_count >= IDX_DST_LO && r_count <= IDX_DST_HI) ?
                  {r_dst[23:0], b} : r_dst;
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;
    end

    assign ihl       = n_first[3:0];
    assign version   = n_first[7:4];
    assign hdr_bytes = {10'd0, ihl, 2'b00};

    // Drive the checksum accumulator
    always_comb begin
        o_sum_ctl.en      = i_adv;
        o_sum_ctl.clear   = i_item.last;
        o_sum_ctl.in_span = (r_count < hdr_bytes);
        o_sum_ctl.odd     = r_count[0];
    end

    // Check status in priority order against the updated byte count
    always_comb begin
        if (n_count < MIN_HEADER_BYTES) begin
            status = ST_SHORT;
        end else if (version != IP_VERSION) begin
            status = ST_BAD_VERSION;
        end else if (ihl < MIN_IHL || hdr_bytes > n_count) begin
            status = ST_BAD_IHL;
        end else if (n_length > n_count) begin
            status = ST_LEN_OVER;
        end else if (n_length < hdr_bytes) begin
            status = ST_LEN_UNDER;
        end else begin
            status = ST_OK;
        end
    end

    // Build the result; zero all header fields on error
    always_comb begin
        o_result               = '0;
        o_result.status        = status;
        o_result.direction_out = i_item.direction;
        if (status == ST_OK) begin
            o_result.header_words    = ihl;
            o_result.hop_limit       = n_ttl;
            o_result.protocol_number = n_proto;
            o_result.source_address  = n_src;
            o_result.dest_address    = n_dst;
            o_result.datagram_length = n_length;
            o_result.checksum_good   = i_sum_good;
            o_result.payload_length  = n_length - hdr_bytes;
        end
    end

    // Advance on each byte, drop all state after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_item.last)) begin
            r_count  <= 16'd0;
            r_first  <= 8'd0;
            r_length <= 16'd0;
            r_ttl    <= 8'd0;
            r_proto  <= 8'd0;
            r_src    <= 32'd0;
            r_dst    <= 32'd0;
        end else if (i_adv) begin
            r_count  <= n_count;
            r_first  <= n_first;
            r_length <= n_length;
            r_ttl    <= n_ttl;
            r_proto  <= n_proto;
            r_src    <= n_src;
            r_dst    <= n_dst;
        end
    end

endmodule

// ===== sv/ipv4_header_parser_unit.sv =====
// IPv4 header parser top level: input register, field/checksum logic, result register.
// A final byte's result is registered in the result register when the byte advances from the input register.
// Throughput: one byte per cycle; only a final byte waiting on a full, stalled
// result register holds the input, set by the single result register.
// Reset: synchronous active-low i_rst_n clears both valid flags, the byte count,
// captured fields and the checksum sum.
module ipv4_header_parser_unit
    import ihp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      adv;
    logic      sum_good;
    t_sum_ctl  sum_ctl;
    t_out_item result;

    // Stall a registered final byte only while the result register is occupied
    assign adv = r_in_valid && !(r_in.last && r_out_valid && !i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    ihp_fields u_fields (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (r_in),
        .i_sum_good (sum_good),
        .o_sum_ctl  (sum_ctl),
        .o_result   (result)
    );

    ihp_checksum u_checksum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sum_ctl),
        .i_data_byte (r_in.data_byte),
        .o_sum_good  (sum_good)
    );

    // Result register: load on a final byte, release on output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in.last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A registered byte that is not final never stalls
    a_nonlast_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in.last) |-> adv)
        else $error("non-final byte stalled");

    // Error results carry zeroed header fields
    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.source_address == 32'd0 && o_out_data.payload_length == 16'd0
         && o_out_data.checksum_good == 1'b0))
        else $error("error result with nonzero fields");

    // Good results carry a legal header length
    a_ok_ihl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OK) |->
        (o_out_data.header_words >= MIN_IHL
         && o_out_data.datagram_length >= o_out_data.payload_length))
        else $error("ok result with bad header length");

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost");

endmodule
